@@ rtl/core/inversion_count_permutations_mod_unit_macros.svh @@
// Assertion macros shared by the inversion count unit.
// Needs no other file; the asserting modules include it by name.
// The macros expect a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef INVERSION_COUNT_PERMUTATIONS_MOD_UNIT_MACROS_SVH
`define INVERSION_COUNT_PERMUTATIONS_MOD_UNIT_MACROS_SVH
`ifndef SYNTH
`define ICPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ICPM_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ICPM_ASSERT(label, prop, msg)
`define ICPM_NEVER(label, cond, msg)
`endif
`endif

@@ rtl/core/icpm_pkg.sv @@
// Shared constants, types and modular helpers for the inversion count unit.
// Has no dependencies; icpm_ctrl, icpm_dp, the top level and the testbench import it.
package icpm_pkg;

    localparam int DATA_W     = 30;
    localparam int N_LEN_W    = 11;
    localparam int K_TARGET_W = 10;
    localparam int DEF_MAX_N  = 1024;
    localparam int DEF_MAX_K  = 1023;

    localparam logic [DATA_W-1:0] MOD_P = 30'd1000000007;

    typedef struct packed {
        logic load;
        logic clr_issue;
        logic fwd_init;
        logic fwd_issue;
        logic bwd_init;
        logic bwd_issue;
        logic next_row;
        logic rd_final;
        logic take_result;
    } t_icpm_cmd;

    typedef struct packed {
        logic j_at_k;
        logic bwd_last;
        logic k_zero;
        logic bwd_empty;
        logic rows_done;
        logic out_busy;
    } t_icpm_sts;

    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MOD_P}) begin
            s = s - {1'b0, MOD_P};
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + {1'b0, MOD_P} - {1'b0, b};
        end
        return d[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/core/inversion_count_permutations_mod_unit.sv @@
// Inversion count unit: number of permutations of length n with exactly k inversions,
// modulo 1000000007. Top level; depends on icpm_pkg, icpm_ctrl, icpm_dp and icpm_ram.
//
// A request carries i_n_len and i_k_target on i_in_valid / o_in_ready; values above
// MAX_N and MAX_K are saturated. The answer leaves on o_out_valid / i_out_ready as
// o_count_mod. One request is worked on at a time, and o_in_ready is high only while
// the sequencer is idle, so a new request is taken only after the previous answer
// is registered, and never while the last request is still being worked on.
// The row store is a RAM of MAX_K+1 entries doing one read-modify-write per cycle,
// which sets the latency; it grows with n times k, and when k is zero the forward
// and backward passes are skipped.
// A finished answer waits in an output register, so a stalled receiver does not
// block the next request; the unit only holds its last step until that register
// is free again. Reset empties the output register and returns the sequencer to
// idle; the row store needs no clearing, as every request rewrites what it reads.
module inversion_count_permutations_mod_unit import icpm_pkg::*; #(
    parameter int MAX_N = DEF_MAX_N,
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [N_LEN_W-1:0]    i_n_len,
    input  logic [K_TARGET_W-1:0] i_k_target,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_count_mod
);

    t_icpm_cmd cmd;
    t_icpm_sts sts;

    icpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    icpm_dp #(
        .MAX_N (MAX_N),
        .MAX_K (MAX_K)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_len     (i_n_len),
        .i_k_target  (i_k_target),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_count_mod (o_count_mod)
    );

endmodule

@@ rtl/core/icpm_ram.sv @@
// Generic RAM with one write port and two registered read ports.
// Has no dependencies.
module icpm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/icpm_ctrl.sv @@
// Sequencer of the inversion count unit: clear, forward and backward passes, readout.
// Depends on icpm_pkg and the assertion macro header.
`include "inversion_count_permutations_mod_unit_macros.svh"

module icpm_ctrl import icpm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_icpm_sts i_sts,
    output t_icpm_cmd o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CLEAR     = 3'd1;
    localparam logic [2:0] S_ROW       = 3'd2;
    localparam logic [2:0] S_FWD       = 3'd3;
    localparam logic [2:0] S_FWD_DRAIN = 3'd4;
    localparam logic [2:0] S_BWD       = 3'd5;
    localparam logic [2:0] S_FINAL     = 3'd6;
    localparam logic [2:0] S_FETCH     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_issue = 1'b1;
                if (i_sts.j_at_k) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (i_sts.rows_done || i_sts.k_zero) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.fwd_init = 1'b1;
                    n_state        = S_FWD;
                end
            end
            S_FWD: begin
                o_cmd.fwd_issue = 1'b1;
                if (i_sts.j_at_k) begin
                    n_state = S_FWD_DRAIN;
                end
            end
            S_FWD_DRAIN: begin
                if (i_sts.bwd_empty) begin
                    o_cmd.next_row = 1'b1;
                    n_state        = S_ROW;
                end else begin
                    o_cmd.bwd_init = 1'b1;
                    n_state        = S_BWD;
                end
            end
            S_BWD: begin
                o_cmd.bwd_issue = 1'b1;
                if (i_sts.bwd_last) begin
                    o_cmd.next_row = 1'b1;
                    n_state        = S_ROW;
                end
            end
            S_FINAL: begin
                o_cmd.rd_final = 1'b1;
                n_state        = S_FETCH;
            end
            S_FETCH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.take_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ICPM_NEVER(a_fwd_needs_k, (r_state == S_FWD) && i_sts.k_zero, "forward pass with k of zero")
    `ICPM_NEVER(a_bwd_range, (r_state == S_BWD) && i_sts.bwd_empty, "backward pass below row")
    `ICPM_ASSERT(a_final_done, (r_state == S_FINAL) |-> (i_sts.rows_done || i_sts.k_zero), "early readout")

endmodule

@@ rtl/core/icpm_dp.sv @@
// Datapath of the inversion count unit: counters, row store, modular update and result register.
// Depends on icpm_pkg, icpm_ram and the assertion macro header.
`include "inversion_count_permutations_mod_unit_macros.svh"

module icpm_dp import icpm_pkg::*; #(
    parameter int MAX_N = DEF_MAX_N,
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [N_LEN_W-1:0]    i_n_len,
    input  logic [K_TARGET_W-1:0] i_k_target,
    input  t_icpm_cmd             i_cmd,
    output t_icpm_sts             o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_count_mod
);

    localparam int AW  = $clog2(MAX_K + 1);
    localparam int NW  = $clog2(MAX_N + 2);
    localparam int CWN = (NW > N_LEN_W) ? NW : N_LEN_W;
    localparam int CWK = (AW > K_TARGET_W) ? AW : K_TARGET_W;
    localparam int IW  = (NW > AW) ? NW : AW;
    localparam logic [CWN-1:0] MAX_N_C = CWN'(MAX_N);
    localparam logic [CWK-1:0] MAX_K_C = CWK'(MAX_K);

    logic [NW-1:0]     r_n;
    logic [NW-1:0]     r_i;
    logic [AW-1:0]     r_k;
    logic [AW-1:0]     r_j;
    logic [DATA_W-1:0] r_prev;
    logic              r_p_valid;
    logic              r_p_fwd;
    logic [AW-1:0]     r_p_addr;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic [CWN-1:0]    n_ext;
    logic [CWN-1:0]    n_sat;
    logic [CWK-1:0]    k_ext;
    logic [CWK-1:0]    k_sat;
    logic [IW-1:0]     j_wide;
    logic [IW-1:0]     i_wide;
    logic [IW-1:0]     k_wide;
    logic [IW-1:0]     jmi_wide;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re_a;
    logic [AW-1:0]     raddr_a;
    logic [DATA_W-1:0] rdata_a;
    logic              re_b;
    logic [AW-1:0]     raddr_b;
    logic [DATA_W-1:0] rdata_b;

    assign n_ext    = CWN'(i_n_len);
    assign n_sat    = (n_ext > MAX_N_C) ? MAX_N_C : n_ext;
    assign k_ext    = CWK'(i_k_target);
    assign k_sat    = (k_ext > MAX_K_C) ? MAX_K_C : k_ext;
    assign j_wide   = IW'(r_j);
    assign i_wide   = IW'(r_i);
    assign k_wide   = IW'(r_k);
    assign jmi_wide = j_wide - i_wide;

    assign o_sts.j_at_k    = (r_j == r_k);
    assign o_sts.bwd_last  = (j_wide == i_wide);
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.bwd_empty = (k_wide < i_wide);
    assign o_sts.rows_done = (r_i > r_n);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign re_a    = i_cmd.fwd_issue || i_cmd.bwd_issue || i_cmd.rd_final;
    assign raddr_a = i_cmd.rd_final ? r_k : r_j;
    assign re_b    = i_cmd.bwd_issue;
    assign raddr_b = jmi_wide[AW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_j;
        wdata = '0;
        if (i_cmd.clr_issue) begin
            we    = 1'b1;
            wdata = (r_j == '0) ? DATA_W'(1) : '0;
        end else if (r_p_valid) begin
            we    = 1'b1;
            waddr = r_p_addr;
            wdata = r_p_fwd ? add_mod(rdata_a, r_prev) : sub_mod(rdata_a, rdata_b);
        end
    end

    icpm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_K + 1)
    ) u_row (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re_a    (re_a),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (re_b),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= NW'(n_sat);
            r_k <= AW'(k_sat);
            r_i <= NW'(2);
            r_j <= '0;
        end else if (i_cmd.fwd_init) begin
            r_j <= AW'(1);
        end else if (i_cmd.bwd_init) begin
            r_j <= r_k;
        end else if (i_cmd.clr_issue || i_cmd.fwd_issue) begin
            r_j <= r_j + AW'(1);
        end else if (i_cmd.bwd_issue) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.next_row) begin
            r_i <= r_i + NW'(1);
        end
        if (i_cmd.fwd_init) begin
            r_prev <= DATA_W'(1);
        end else if (r_p_valid && r_p_fwd) begin
            r_prev <= wdata;
        end
        r_p_fwd  <= i_cmd.fwd_issue;
        r_p_addr <= r_j;
        if (i_cmd.take_result) begin
            r_out_data <= rdata_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.fwd_issue || i_cmd.bwd_issue;
            if (i_cmd.take_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_mod = r_out_data;

    `ICPM_NEVER(a_rd_a_clash, r_p_valid && re_a && (raddr_a == r_p_addr), "read A meets write")
    `ICPM_NEVER(a_rd_b_clash, r_p_valid && re_b && (raddr_b == r_p_addr), "read B meets write")
    `ICPM_ASSERT(a_wdata_mod, we |-> (wdata < MOD_P), "row entry not reduced")

endmodule

@@ tb/sv/inversion_count_permutations_mod_unit_tb.sv @@
// Self-checking testbench for the inversion count unit: Mahonian numbers modulo 1000000007.
// Depends on icpm_pkg and inversion_count_permutations_mod_unit; a scoreboard class
// predicts each count, plain tasks drive requests with random idling, and a separate process applies back-pressure.
`timescale 1ns / 1ps

module inversion_count_permutations_mod_unit_tb;
    import icpm_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SAT_N           = 1024;
    localparam int SAT_K           = 1023;
    localparam int RANDOM_REQUESTS = 100;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int STALL_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 20;
    localparam logic [DATA_W:0] PRIME = 31'd1000000007;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [N_LEN_W-1:0]    i_n_len;
    logic [K_TARGET_W-1:0] i_k_target;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DATA_W-1:0]     o_count_mod;

    bit idle_on;
    bit hold_off_request;
    int unsigned quiet_cycles;

    class mahonian_scoreboard;
        logic [DATA_W-1:0] row [0:SAT_K];
        logic [DATA_W-1:0] expected_counts [$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                            input logic [DATA_W-1:0] b);
            logic [DATA_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s >= PRIME) begin
                s = s - PRIME;
            end
            return s[DATA_W-1:0];
        endfunction

        function logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                            input logic [DATA_W-1:0] b);
            logic [DATA_W:0] s;
            if (a >= b) begin
                s = {1'b0, a} - {1'b0, b};
            end else begin
                s = {1'b0, a} + PRIME - {1'b0, b};
            end
            return s[DATA_W-1:0];
        endfunction

        // Prefix sums followed by a backward subtraction give the next row of the
        // Mahonian triangle; lengths and targets above the limits are saturated.
        function logic [DATA_W-1:0] count_permutations(input logic [N_LEN_W-1:0] n_in,
                                                       input logic [K_TARGET_W-1:0] k_in);
            int n;
            int k;
            int i;
            int j;
            n = (n_in > SAT_N) ? SAT_N : int'(n_in);
            k = (k_in > SAT_K) ? SAT_K : int'(k_in);
            for (j = 0; j <= k; j++) begin
                row[j] = '0;
            end
            row[0] = DATA_W'(1);
            for (i = 2; i <= n; i++) begin
                for (j = 1; j <= k; j++) begin
                    row[j] = mod_add(row[j], row[j-1]);
                end
                for (j = k; j >= i; j--) begin
                    row[j] = mod_sub(row[j], row[j-i]);
                end
            end
            return row[k];
        endfunction

        function void note_request(input logic [N_LEN_W-1:0] n_in,
                                   input logic [K_TARGET_W-1:0] k_in);
            expected_counts.push_back(count_permutations(n_in, k_in));
        endfunction

        function void check_answer(input logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_counts.size() == 0) begin
                $error("count_mod: unexpected answer %0d with no request waiting", got);
                errors++;
            end else begin
                want = expected_counts.pop_front();
                if (got !== want) begin
                    $error("count_mod mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    mahonian_scoreboard counts = new();

    inversion_count_permutations_mod_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_n_len     (i_n_len),
        .i_k_target  (i_k_target),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_count_mod (o_count_mod)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                counts.note_request(i_n_len, i_k_target);
            end
            if (o_out_valid && i_out_ready) begin
                counts.check_answer(o_count_mod);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL inversion_count_permutations_mod_unit");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= !idle_on || ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic send_request(input logic [N_LEN_W-1:0] n,
                                input logic [K_TARGET_W-1:0] k);
        if (idle_on && $urandom_range(99) < 20) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_n_len    <= n;
        i_k_target <= k;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Most requests are small, since the latency grows with n times k.
    task automatic send_random_request(input bit tiny);
        int roll;
        roll = $urandom_range(99);
        if (tiny) begin
            send_request(N_LEN_W'($urandom_range(0, 4)), K_TARGET_W'($urandom_range(0, 4)));
        end else if (roll < 78) begin
            send_request(N_LEN_W'($urandom_range(0, 24)), K_TARGET_W'($urandom_range(0, 48)));
        end else if (roll < 88) begin
            send_request(N_LEN_W'($urandom_range(1024, 2047)),
                         K_TARGET_W'($urandom_range(0, 3)));
        end else if (roll < 96) begin
            send_request(N_LEN_W'($urandom_range(0, 4)), K_TARGET_W'($urandom_range(0, 1023)));
        end else begin
            send_request(N_LEN_W'($urandom_range(25, 200)), K_TARGET_W'($urandom_range(0, 12)));
        end
    endtask

    initial begin
        int idx;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_n_len          = '0;
        i_k_target       = '0;
        idle_on          = 1'b1;
        hold_off_request = 1'b0;
        quiet_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(1, 0);
        send_request(1, 1);
        send_request(0, 0);
        send_request(0, 5);
        send_request(0, 1023);
        send_request(2, 0);
        send_request(2, 1);
        send_request(3, 3);
        send_request(3, 10);
        send_request(4, 3);
        send_request(5, 5);
        send_request(12, 66);
        send_request(10, 45);
        send_request(10, 20);
        send_request(2047, 0);
        send_request(1025, 1);
        send_request(1024, 1);
        send_request(2047, 2);
        send_request(1024, 3);
        send_request(1, 1023);
        send_request(2, 1023);
        send_request(30, 200);
        send_request(64, 1023);

        for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
            idle_on = !(idx >= 20 && idx < 50);
            if (idx == 60) begin
                hold_off_request = 1'b1;
            end
            if (idx == 85) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (counts.pending() != 0) @(posedge i_clk);
            end
            send_random_request(idx >= 60 && idx < 68);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (counts.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (counts.errors == 0) begin
            $display("PASS inversion_count_permutations_mod_unit");
        end else begin
            $display("FAIL inversion_count_permutations_mod_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/icpm_pkg.sv
rtl/core/icpm_ram.sv
rtl/core/icpm_ctrl.sv
rtl/core/icpm_dp.sv
rtl/core/inversion_count_permutations_mod_unit.sv
tb/sv/inversion_count_permutations_mod_unit_tb.sv
